>>> rtl/clsc_pkg.sv
// Shared types and constants for the charlieplexed LED scan controller.
package clsc_pkg;

	typedef enum logic [2:0] {
		KIND_SCAN   = 3'd0,
		KIND_SECOND = 3'd1,
		KIND_SET    = 3'd2,
		KIND_GAUGE  = 3'd3,
		KIND_CHARGE = 3'd4,
		KIND_ERROR  = 3'd5,
		KIND_INIT   = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		CFG_PIN_TABLE     = 3'd0,
		CFG_GAUGE_MODE    = 3'd1,
		CFG_POWER_LED_POS = 3'd2,
		CFG_BAR_ONE_POS   = 3'd3,
		CFG_BAR_TWO_POS   = 3'd4,
		CFG_BAR_THREE_POS = 3'd5,
		CFG_FLICKER_LIMIT = 3'd6
	} cfg_idx_t;

	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_ON      = 2'd1;
	localparam logic [1:0] MODE_BLINK   = 2'd2;
	localparam logic [1:0] MODE_FLICKER = 2'd3;

	localparam logic [1:0] CODE_LOW   = 2'd0;
	localparam logic [1:0] CODE_HIGH  = 2'd1;
	localparam logic [1:0] CODE_FLOAT = 2'd2;

	localparam logic [1:0] GAUGE_POWER = 2'd1;
	localparam logic [1:0] GAUGE_BARS  = 2'd2;

	localparam int TABLE_BITS = 24;

	localparam logic [6:0] SOC_HIGH = 7'd80;
	localparam logic [6:0] SOC_LOW  = 7'd20;

	localparam logic [23:0] PIN_TABLE_RST     = 24'd0;
	localparam logic [1:0]  GAUGE_MODE_RST    = GAUGE_BARS;
	localparam logic [1:0]  POWER_LED_POS_RST = 2'd0;
	localparam logic [1:0]  BAR_ONE_POS_RST   = 2'd0;
	localparam logic [1:0]  BAR_TWO_POS_RST   = 2'd1;
	localparam logic [1:0]  BAR_THREE_POS_RST = 2'd2;
	localparam logic [7:0]  FLICKER_LIMIT_RST = 8'd30;

endpackage

>>> rtl/clsc_if.sv
// Handshake interfaces: event words, status words and register writes.
interface clsc_cmd_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  kind;
	logic        [2:0]  led;
	logic        [1:0]  mode;
	logic signed [15:0] timeout;
	logic        [6:0]  soc;
	logic               flag;

	modport source (output valid, kind, led, mode, timeout, soc, flag, input ready);
	modport sink (input valid, kind, led, mode, timeout, soc, flag, output ready);
endinterface

interface clsc_status_if;
	logic       valid;
	logic       ready;
	logic [2:0] pin_drive_enable;
	logic [2:0] pin_level;
	logic [1:0] scan_led;
	logic [7:0] led_modes;

	modport source (output valid, pin_drive_enable, pin_level, scan_led, led_modes,
		input ready);
	modport sink (input valid, pin_drive_enable, pin_level, scan_led, led_modes,
		output ready);
endinterface

interface clsc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/clsc_pin_decode.sv
// Pin table lookup: drive enables and levels for one LED.
module clsc_pin_decode #(
	parameter int PIN_COUNT = 3,
	parameter int PIN_W     = 3
) (
	input  logic [23:0]      pin_table,
	input  logic [2:0]       led,
	output logic [PIN_W-1:0] drive,
	output logic [PIN_W-1:0] level
);
	import clsc_pkg::*;

	always_comb begin
		logic [7:0] pos;
		logic [1:0] code;
		drive = '0;
		level = '0;
		for (int p = 0; p < PIN_COUNT; p++) begin
			pos = 8'(2 * (int'(led) * PIN_COUNT + p));
			// slots past the end of the table float
			if (pos >= 8'(TABLE_BITS - 1)) begin
				code = CODE_FLOAT;
			end else begin
				code = 2'(pin_table >> pos);
			end
			case (code)
				CODE_LOW: begin
					drive[p] = 1'b1;
				end
				CODE_HIGH: begin
					drive[p] = 1'b1;
					level[p] = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/charlieplex_led_scan_controller.sv
// Charlieplexed LED scan controller top level.
// Each event word passes the input stage, then the status register.
// Throughput: one event word per cycle; the input stage refills while the
// status register is read out, so stalls come only from the status side.
// Reset (arst_n low): all LEDs on with timeout 0, blink and flicker flags set,
// charging clear, scan at LED 0, pins floating, registers at their defaults.
module charlieplex_led_scan_controller #(
	parameter int NUM_LEDS     = 4,
	parameter int PIN_COUNT    = 3,
	parameter int TIMEOUT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	clsc_cfg_if.sink   cfg,
	clsc_cmd_if.sink   cmd,
	clsc_status_if.source status
);
	import clsc_pkg::*;

	localparam int PIN_W = (PIN_COUNT > 3) ? PIN_COUNT : 3;

	// configuration
	logic [23:0] pin_table_q;
	logic [1:0]  gauge_mode_q;
	logic [1:0]  power_pos_q;
	logic [1:0]  bar_one_q;
	logic [1:0]  bar_two_q;
	logic [1:0]  bar_three_q;
	logic [7:0]  flicker_limit_q;

	// input stage
	logic               valid_s1;
	kind_t              kind_s1;
	logic [2:0]         led_s1;
	logic [1:0]         mode_s1;
	logic signed [15:0] timeout_s1;
	logic [6:0]         soc_s1;
	logic               flag_s1;

	// block state; pin, served and mode registers double as the status word
	logic [1:0]                     mode_q [NUM_LEDS];
	logic signed [TIMEOUT_BITS-1:0] to_q [NUM_LEDS];
	logic                           blink_q;
	logic                           flick_q;
	logic [7:0]                     cnt_q;
	logic [2:0]                     scan_q;
	logic                           chg_q;
	logic [PIN_W-1:0]               drive_q;
	logic [PIN_W-1:0]               level_q;
	logic [2:0]                     served_q;
	logic                           res_valid_q;

	logic [1:0]                     mode_d [NUM_LEDS];
	logic signed [TIMEOUT_BITS-1:0] to_d [NUM_LEDS];
	logic                           blink_d;
	logic                           flick_d;
	logic [7:0]                     cnt_d;
	logic [2:0]                     scan_d;
	logic                           chg_d;
	logic [PIN_W-1:0]               drive_d;
	logic [PIN_W-1:0]               level_d;
	logic [2:0]                     served_d;

	logic             adv;
	logic [2:0]       scan_idx;
	logic [PIN_W-1:0] dec_drive;
	logic [PIN_W-1:0] dec_level;
	logic [7:0]       packed_modes;

	assign adv       = valid_s1 && (!res_valid_q || status.ready);
	assign cmd.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	// scan pointer past the last LED wraps to zero before use
	assign scan_idx = ({1'b0, scan_q} >= 4'(NUM_LEDS)) ? 3'd0 : scan_q;

	clsc_pin_decode #(
		.PIN_COUNT(PIN_COUNT),
		.PIN_W    (PIN_W)
	) u_pin_decode (
		.pin_table(pin_table_q),
		.led      (scan_idx),
		.drive    (dec_drive),
		.level    (dec_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_table_q     <= PIN_TABLE_RST;
			gauge_mode_q    <= GAUGE_MODE_RST;
			power_pos_q     <= POWER_LED_POS_RST;
			bar_one_q       <= BAR_ONE_POS_RST;
			bar_two_q       <= BAR_TWO_POS_RST;
			bar_three_q     <= BAR_THREE_POS_RST;
			flicker_limit_q <= FLICKER_LIMIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_PIN_TABLE:     pin_table_q     <= cfg.data;
				CFG_GAUGE_MODE:    gauge_mode_q    <= cfg.data[1:0];
				CFG_POWER_LED_POS: power_pos_q     <= cfg.data[1:0];
				CFG_BAR_ONE_POS:   bar_one_q       <= cfg.data[1:0];
				CFG_BAR_TWO_POS:   bar_two_q       <= cfg.data[1:0];
				CFG_BAR_THREE_POS: bar_three_q     <= cfg.data[1:0];
				CFG_FLICKER_LIMIT: flicker_limit_q <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_s1    <= kind_t'(cmd.kind);
			led_s1     <= cmd.led;
			mode_s1    <= cmd.mode;
			timeout_s1 <= cmd.timeout;
			soc_s1     <= cmd.soc;
			flag_s1    <= cmd.flag;
		end
	end

	always_comb begin
		logic [1:0] chg_mode;
		logic [1:0] bar_a;
		logic [1:0] bar_b;
		logic [1:0] bar_c;
		logic [1:0] sel_mode;
		logic       lit;

		mode_d   = mode_q;
		to_d     = to_q;
		blink_d  = blink_q;
		flick_d  = flick_q;
		cnt_d    = cnt_q;
		scan_d   = scan_q;
		chg_d    = chg_q;
		drive_d  = drive_q;
		level_d  = level_q;
		served_d = served_q;
		chg_mode = chg_q ? MODE_BLINK : MODE_ON;
		bar_a    = MODE_OFF;
		bar_b    = MODE_OFF;
		bar_c    = chg_mode;
		sel_mode = MODE_OFF;
		lit      = 1'b0;

		case (kind_s1)
			KIND_SCAN: begin
				if (cnt_q > flicker_limit_q) begin
					cnt_d   = 8'd0;
					flick_d = !flick_q;
				end
				for (int i = 0; i < NUM_LEDS; i++) begin
					if (scan_idx == 3'(i)) begin
						sel_mode = mode_q[i];
					end
				end
				lit = (sel_mode == MODE_ON) || (sel_mode == MODE_FLICKER && flick_d) ||
					(sel_mode == MODE_BLINK && blink_q);
				drive_d  = lit ? dec_drive : '0;
				level_d  = lit ? dec_level : '0;
				served_d = scan_idx;
				scan_d   = scan_idx + 3'd1;
				cnt_d    = cnt_d + 8'd1;
			end
			KIND_SECOND: begin
				blink_d = !blink_q;
				for (int i = 0; i < NUM_LEDS; i++) begin
					if (to_q[i] == '0) begin
						mode_d[i] = MODE_OFF;
					end else if (!to_q[i][TIMEOUT_BITS-1]) begin
						to_d[i] = to_q[i] - TIMEOUT_BITS'(1);
					end
				end
			end
			KIND_SET: begin
				for (int i = 0; i < NUM_LEDS; i++) begin
					if (led_s1 == 3'(i)) begin
						mode_d[i] = mode_s1;
						to_d[i]   = TIMEOUT_BITS'(timeout_s1);
					end
				end
			end
			KIND_GAUGE: begin
				if (soc_s1 > SOC_HIGH && !flag_s1) begin
					bar_a = chg_mode;
					bar_b = MODE_ON;
					bar_c = MODE_ON;
				end else if (soc_s1 > SOC_LOW && !flag_s1) begin
					bar_b = chg_mode;
					bar_c = MODE_ON;
				end
				for (int i = 0; i < NUM_LEDS; i++) begin
					if (gauge_mode_q == GAUGE_POWER && {1'b0, power_pos_q} == 3'(i)) begin
						mode_d[i] = chg_mode;
						to_d[i]   = '1;
					end
					// bottom bar written last so it wins on overlap
					if (gauge_mode_q == GAUGE_BARS) begin
						if ({1'b0, bar_one_q} == 3'(i)) begin
							mode_d[i] = bar_a;
							to_d[i]   = '1;
						end
						if ({1'b0, bar_two_q} == 3'(i)) begin
							mode_d[i] = bar_b;
							to_d[i]   = '1;
						end
						if ({1'b0, bar_three_q} == 3'(i)) begin
							mode_d[i] = bar_c;
							to_d[i]   = '1;
						end
					end
				end
			end
			KIND_CHARGE: begin
				chg_d = flag_s1;
			end
			KIND_ERROR: begin
				for (int i = 0; i < NUM_LEDS; i++) begin
					mode_d[i] = {1'b0, 1'(i) ^ blink_q};
				end
				blink_d = !blink_q;
			end
			KIND_INIT: begin
				for (int i = 0; i < NUM_LEDS; i++) begin
					mode_d[i] = flag_s1 ? MODE_ON : MODE_OFF;
					to_d[i]   = flag_s1 ? '0 : '1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				mode_q[i] <= MODE_ON;
				to_q[i]   <= '0;
			end
			blink_q     <= 1'b1;
			flick_q     <= 1'b1;
			cnt_q       <= 8'd0;
			scan_q      <= 3'd0;
			chg_q       <= 1'b0;
			drive_q     <= '0;
			level_q     <= '0;
			served_q    <= 3'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				mode_q   <= mode_d;
				to_q     <= to_d;
				blink_q  <= blink_d;
				flick_q  <= flick_d;
				cnt_q    <= cnt_d;
				scan_q   <= scan_d;
				chg_q    <= chg_d;
				drive_q  <= drive_d;
				level_q  <= level_d;
				served_q <= served_d;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (status.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_pack
		if (g < NUM_LEDS) begin : g_led
			assign packed_modes[2*g +: 2] = mode_q[g];
		end else begin : g_none
			assign packed_modes[2*g +: 2] = MODE_OFF;
		end
	end

	assign status.valid            = res_valid_q;
	assign status.pin_drive_enable = drive_q[2:0];
	assign status.pin_level        = level_q[2:0];
	assign status.scan_led         = served_q[1:0];
	assign status.led_modes        = packed_modes;

endmodule

>>> rtl/clsc_checker.sv
// Port-level checks for the LED scan controller, bound to the top level.
module clsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       status_valid,
	input logic       status_ready,
	input logic [2:0] status_drive,
	input logic [2:0] status_level,
	input logic [1:0] status_scan_led,
	input logic [7:0] status_led_modes
);

	// a stalled status word stays valid
	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=> status_valid)
		else $error("status word dropped while stalled");

	// a stalled status word keeps its payload
	a_status_stable: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=> $stable(status_drive) &&
		$stable(status_level) && $stable(status_scan_led) && $stable(status_led_modes))
		else $error("status payload changed while stalled");

	// a taken event word yields a status word via input and status registers
	a_event_to_status: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |-> ##2 status_valid)
		else $error("event word produced no status word");

	// status only appears after an event word was taken
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(status_valid) |-> $past(cmd_valid && cmd_ready, 2))
		else $error("status word without event word");

endmodule

bind charlieplex_led_scan_controller clsc_checker u_clsc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.status_valid    (status.valid),
	.status_ready    (status.ready),
	.status_drive    (status.pin_drive_enable),
	.status_level    (status.pin_level),
	.status_scan_led (status.scan_led),
	.status_led_modes(status.led_modes)
);
